// ===== rtl/core/rsbs_pkg.sv =====
// ----------------------------------------------------------------------------
// rsbs_pkg
// Shared constants, types and helpers of the record sort and search core.
// ----------------------------------------------------------------------------
package rsbs_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int ID_W   = 31;
   localparam int SLOT_W = 4;
   localparam int POS_W  = 4;
   localparam int CFG_W  = 5;
   localparam int CMD_W  = 2;

   // request tdata layout
   localparam int SLOT_LSB  = 0;
   localparam int RID_LSB   = SLOT_LSB + SLOT_W;
   localparam int RAV_BIT   = RID_LSB + ID_W;
   localparam int KEY_LSB   = RAV_BIT + 1;
   localparam int REQ_USED  = KEY_LSB + ID_W;
   localparam int REQ_DATA_W = ((REQ_USED + 7) / 8) * 8;

   // response tdata layout
   localparam int FOUND_BIT  = 0;
   localparam int POS_LSB    = FOUND_BIT + 1;
   localparam int MAV_BIT    = POS_LSB + POS_W;
   localparam int RSP_USED   = MAV_BIT + 1;
   localparam int RSP_DATA_W = ((RSP_USED + 7) / 8) * 8;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

   typedef logic [ID_W-1:0]  id_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_SORT   = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SORT_OUTER,
      ST_SORT_KEY,
      ST_SORT_RD,
      ST_SORT_CMP,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_SRCH_FIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic   flag;
      id_type id;
   } entry_type;

   typedef struct packed {
      logic      wr_en;
      idx_type   wr_addr;
      entry_type wr_data;
      logic      rd_en;
      idx_type   rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_type;

   function automatic cnt_type active_count(input logic [CFG_W-1:0] cfg);
      if (int'(cfg) > TABLE_DEPTH) begin
         return CNT_W'(TABLE_DEPTH);
      end
      return CNT_W'(cfg);
   endfunction

endpackage

// ===== rtl/core/record_sort_and_binary_search_core.sv =====
// ----------------------------------------------------------------------------
// record_sort_and_binary_search_core
// Record table with stable insertion sort by ID and lower-bound key search.
//
//   group  dir  handshake              payload
//   req    in   req_tvalid/req_tready  tuser cmd, tdata slot..search_key
//   rsp    out  rsp_tvalid/rsp_tready  tdata found, position, match_available
//   csr    in   csr_valid/csr_ready    csr_data entry_count
//
// load and no-op beats go straight to the result; search probes the midpoint until the window closes
// sort reads and shifts entries one at a time through the single table read port
// one beat is in work at a time; the next beat is taken while a result waits
// reset is synchronous and sets entry_count to 16; the table is not cleared
// ----------------------------------------------------------------------------
module record_sort_and_binary_search_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // slot, record_id, record_available, search_key, zero pad
   input  logic [rsbs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cmd
   input  logic [rsbs_pkg::CMD_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // found, position, match_available, zero pad
   output logic [rsbs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rsbs_pkg::CFG_W-1:0]        csr_data
);

   rsbs_pkg::state_type   state_ff, state_in;
   logic [rsbs_pkg::CFG_W-1:0] cfg_ff;
   rsbs_pkg::cnt_type     cnt_ff, cnt_in;
   rsbs_pkg::cnt_type     i_ff, i_in;
   rsbs_pkg::cnt_type     j_ff, j_in;
   rsbs_pkg::cnt_type     lo_ff, lo_in;
   rsbs_pkg::cnt_type     hi_ff, hi_in;
   rsbs_pkg::entry_type   key_ff, key_in;
   logic                  res_found_ff, res_found_in;
   logic [rsbs_pkg::POS_W-1:0] res_pos_ff, res_pos_in;
   logic                  res_avail_ff, res_avail_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [rsbs_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   rsbs_pkg::mem_req_type mreq;
   rsbs_pkg::entry_type   rd_data;
   rsbs_pkg::cmp_type     cmp;

   rsbs_pkg::cmd_type     cmd;
   logic [rsbs_pkg::SLOT_W-1:0] slot;
   rsbs_pkg::cnt_type     mid;
   rsbs_pkg::cnt_type     jm1;
   logic                  req_accept;
   logic                  rsp_load;
   logic                  gt;

   rsbs_table u_table (
      .clock   (clock),
      .req     (mreq),
      .rd_data (rd_data)
   );

   rsbs_cmp u_cmp (
      .lhs (rd_data.id),
      .rhs (key_ff.id),
      .res (cmp)
   );

   assign cmd        = rsbs_pkg::cmd_type'(req_tuser);
   assign slot       = req_tdata[rsbs_pkg::SLOT_LSB +: rsbs_pkg::SLOT_W];
   assign req_tready = (state_ff == rsbs_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign mid        = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign jm1        = j_ff - rsbs_pkg::CNT_W'(1);
   assign gt         = !cmp.lt && !cmp.eq;
   assign rsp_load   = (state_ff == rsbs_pkg::ST_DONE) && (!rsp_tvalid_ff || rsp_tready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rsbs_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (cmd)
                  rsbs_pkg::CMD_SORT:   state_in = rsbs_pkg::ST_SORT_OUTER;
                  rsbs_pkg::CMD_SEARCH: state_in = rsbs_pkg::ST_SRCH_RD;
                  rsbs_pkg::CMD_LOAD,
                  rsbs_pkg::CMD_NOP:    state_in = rsbs_pkg::ST_DONE;
               endcase
            end
         end
         rsbs_pkg::ST_SORT_OUTER: begin
            state_in = (i_ff < cnt_ff) ? rsbs_pkg::ST_SORT_KEY : rsbs_pkg::ST_DONE;
         end
         rsbs_pkg::ST_SORT_KEY: state_in = rsbs_pkg::ST_SORT_RD;
         rsbs_pkg::ST_SORT_RD: begin
            state_in = (j_ff == '0) ? rsbs_pkg::ST_SORT_OUTER : rsbs_pkg::ST_SORT_CMP;
         end
         rsbs_pkg::ST_SORT_CMP: begin
            state_in = gt ? rsbs_pkg::ST_SORT_RD : rsbs_pkg::ST_SORT_OUTER;
         end
         rsbs_pkg::ST_SRCH_RD: begin
            if (lo_ff < hi_ff) begin
               state_in = rsbs_pkg::ST_SRCH_CMP;
            end else if (lo_ff < cnt_ff) begin
               state_in = rsbs_pkg::ST_SRCH_FIN;
            end else begin
               state_in = rsbs_pkg::ST_DONE;
            end
         end
         rsbs_pkg::ST_SRCH_CMP: state_in = rsbs_pkg::ST_SRCH_RD;
         rsbs_pkg::ST_SRCH_FIN: state_in = rsbs_pkg::ST_DONE;
         rsbs_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = rsbs_pkg::ST_IDLE;
            end
         end
         default: state_in = rsbs_pkg::ST_IDLE;
      endcase
   end

   // datapath and table control
   always_comb begin
      mreq         = '0;
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      key_in       = key_ff;
      res_found_in = res_found_ff;
      res_pos_in   = res_pos_ff;
      res_avail_in = res_avail_ff;
      unique case (state_ff)
         rsbs_pkg::ST_IDLE: begin
            if (req_accept) begin
               key_in.id    = req_tdata[rsbs_pkg::KEY_LSB +: rsbs_pkg::ID_W];
               key_in.flag  = 1'b0;
               cnt_in       = rsbs_pkg::active_count(cfg_ff);
               hi_in        = rsbs_pkg::active_count(cfg_ff);
               lo_in        = '0;
               i_in         = rsbs_pkg::CNT_W'(1);
               res_found_in = 1'b0;
               res_pos_in   = '0;
               res_avail_in = 1'b0;
               if (cmd == rsbs_pkg::CMD_LOAD && int'(slot) < rsbs_pkg::TABLE_DEPTH) begin
                  mreq.wr_en        = 1'b1;
                  mreq.wr_addr      = rsbs_pkg::IDX_W'(slot);
                  mreq.wr_data.id   = req_tdata[rsbs_pkg::RID_LSB +: rsbs_pkg::ID_W];
                  mreq.wr_data.flag = req_tdata[rsbs_pkg::RAV_BIT];
               end
            end
         end
         rsbs_pkg::ST_SORT_OUTER: begin
            if (i_ff < cnt_ff) begin
               mreq.rd_en   = 1'b1;
               mreq.rd_addr = i_ff[rsbs_pkg::IDX_W-1:0];
            end
         end
         rsbs_pkg::ST_SORT_KEY: begin
            key_in = rd_data;
            j_in   = i_ff;
         end
         rsbs_pkg::ST_SORT_RD: begin
            if (j_ff == '0) begin
               mreq.wr_en   = 1'b1;
               mreq.wr_addr = '0;
               mreq.wr_data = key_ff;
               i_in         = i_ff + rsbs_pkg::CNT_W'(1);
            end else begin
               mreq.rd_en   = 1'b1;
               mreq.rd_addr = jm1[rsbs_pkg::IDX_W-1:0];
            end
         end
         rsbs_pkg::ST_SORT_CMP: begin
            mreq.wr_en   = 1'b1;
            mreq.wr_addr = j_ff[rsbs_pkg::IDX_W-1:0];
            if (gt) begin
               mreq.wr_data = rd_data;
               j_in         = jm1;
            end else begin
               mreq.wr_data = key_ff;
               i_in         = i_ff + rsbs_pkg::CNT_W'(1);
            end
         end
         rsbs_pkg::ST_SRCH_RD: begin
            if (lo_ff < hi_ff) begin
               mreq.rd_en   = 1'b1;
               mreq.rd_addr = mid[rsbs_pkg::IDX_W-1:0];
            end else if (lo_ff < cnt_ff) begin
               mreq.rd_en   = 1'b1;
               mreq.rd_addr = lo_ff[rsbs_pkg::IDX_W-1:0];
            end
         end
         rsbs_pkg::ST_SRCH_CMP: begin
            if (cmp.lt) begin
               lo_in = mid + rsbs_pkg::CNT_W'(1);
            end else begin
               hi_in = mid;
            end
         end
         rsbs_pkg::ST_SRCH_FIN: begin
            if (cmp.eq) begin
               res_found_in = 1'b1;
               res_pos_in   = rsbs_pkg::POS_W'(lo_ff);
               res_avail_in = rd_data.flag;
            end
         end
         rsbs_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      if (rsp_load) begin
         rsp_tvalid_in                                         = 1'b1;
         rsp_data_in                                           = '0;
         rsp_data_in[rsbs_pkg::FOUND_BIT]                      = res_found_ff;
         rsp_data_in[rsbs_pkg::POS_LSB +: rsbs_pkg::POS_W]     = res_pos_ff;
         rsp_data_in[rsbs_pkg::MAV_BIT]                        = res_avail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rsbs_pkg::ST_IDLE;
         cfg_ff        <= rsbs_pkg::CFG_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_valid && csr_ready) begin
            cfg_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      key_ff       <= key_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
      res_avail_ff <= res_avail_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // no table writes while searching
   a_no_write_in_search: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rsbs_pkg::ST_SRCH_RD || state_ff == rsbs_pkg::ST_SRCH_CMP ||
       state_ff == rsbs_pkg::ST_SRCH_FIN) |-> !mreq.wr_en)
      else $error("table write during search");

   // probe window is never empty
   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rsbs_pkg::ST_SRCH_CMP) |-> (lo_ff < hi_ff && hi_ff <= cnt_ff))
      else $error("search window out of range");

   // insertion index stays inside the active range
   a_sort_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rsbs_pkg::ST_SORT_CMP) |-> (j_ff != '0 && j_ff <= i_ff && i_ff < cnt_ff))
      else $error("sort index out of range");

   // a miss reports zero position and flag
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_data_ff[rsbs_pkg::FOUND_BIT]) |->
      (rsp_data_ff[rsbs_pkg::POS_LSB +: rsbs_pkg::POS_W] == '0 &&
       !rsp_data_ff[rsbs_pkg::MAV_BIT]))
      else $error("miss with nonzero payload");

   // a response load raises rsp_tvalid and returns the core to idle
   a_load_from_done: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_tvalid_ff && state_ff == rsbs_pkg::ST_IDLE))
      else $error("response load lost");

endmodule

// ===== rtl/core/rsbs_table.sv =====
// ----------------------------------------------------------------------------
// rsbs_table
// Record store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rsbs_table (
   input  logic                 clock,
   input  rsbs_pkg::mem_req_type req,
   output rsbs_pkg::entry_type  rd_data
);

   rsbs_pkg::entry_type mem_ff [rsbs_pkg::TABLE_DEPTH];
   rsbs_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem_ff[req.wr_addr] <= req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_data_ff <= mem_ff[req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rsbs_cmp.sv =====
// ----------------------------------------------------------------------------
// rsbs_cmp
// Shared ID comparator used by both the sort pass and the binary search.
// ----------------------------------------------------------------------------
module rsbs_cmp (
   input  rsbs_pkg::id_type  lhs,
   input  rsbs_pkg::id_type  rhs,
   output rsbs_pkg::cmp_type res
);

   always_comb begin
      res.lt = (lhs < rhs);
      res.eq = (lhs == rhs);
   end

endmodule
